>>> rtl/core/les_pkg.sv
package les_pkg;

    // Field and datapath widths
    localparam int PERIOD_BITS  = 16;
    localparam int PER_W        = PERIOD_BITS + 4;   // holds 175 + p1 + 7.5*p2
    localparam int TIME_W       = PER_W + 1;         // time + elapsed before wrap
    localparam int ELAPSED_W    = 10;
    localparam int COL_W        = 8;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int EFF_W        = 3;

    // Quarter-wave sine table
    localparam int SINE_DEPTH   = 256;
    localparam int SINE_IDX_W   = $clog2(SINE_DEPTH);
    localparam int SINE_W       = 16;

    // Serial unit counters
    localparam int STEP_W       = $clog2(TIME_W + 1);
    localparam int SCALE_CNT_W  = $clog2(COL_W + 1);
    localparam int ACC_W        = 2 * SINE_W + COL_W;

    localparam logic [PER_W-1:0] SCROLL_LEAD_MS = PER_W'(175);

    // Effect codes
    localparam logic [EFF_W-1:0] EFF_OFF    = 3'd0;
    localparam logic [EFF_W-1:0] EFF_ON     = 3'd1;
    localparam logic [EFF_W-1:0] EFF_BREATH = 3'd2;
    localparam logic [EFF_W-1:0] EFF_FLASH  = 3'd3;
    localparam logic [EFF_W-1:0] EFF_SCROLL = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EFFECT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_P1     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_P2     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT = 3'd6;

    // Sine polynomial coefficients, Q30
    localparam logic [63:0] SQ30_C1 = 64'd1686629713;
    localparam logic [63:0] SQ30_C3 = 64'd693598668;
    localparam logic [63:0] SQ30_C5 = 64'd85569306;
    localparam logic [63:0] SQ30_C7 = 64'd5026995;
    localparam logic [63:0] SQ30_C9 = 64'd172272;

    // Lane 0 red, 1 green, 2 blue
    typedef logic [2:0][COL_W-1:0] les_rgb_t;

    typedef struct packed {
        logic                  start;
        logic [STEP_W-1:0]     steps;
        logic [PER_W-1:0]      rem_init;
        logic [TIME_W-1:0]     dividend;
        logic [PER_W-1:0]      divisor;
    } les_div_cmd_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [SINE_IDX_W-1:0] quo;
        logic [PER_W-1:0]      rem;
    } les_div_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APPLY,
        ST_CHECK,
        ST_MOD,
        ST_EVAL,
        ST_INDEX,
        ST_SQUARE,
        ST_SCALE,
        ST_DONE
    } les_state_t;

    // Table entry i: sin(pi/2 * i / depth) in Q16, odd Horner polynomial in Q30.
    // Evaluated at elaboration only.
    function automatic logic [SINE_W-1:0] les_sine_entry(input int i);
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] v;
        u  = (64'(i) << 30) / SINE_DEPTH;
        u2 = (u * u) >> 30;
        p  = SQ30_C9;
        p  = SQ30_C7 - ((u2 * p) >> 30);
        p  = SQ30_C5 - ((u2 * p) >> 30);
        p  = SQ30_C3 - ((u2 * p) >> 30);
        p  = SQ30_C1 - ((u2 * p) >> 30);
        s  = (u * p) >> 30;
        v  = (s + 64'd8192) >> 14;
        return (v > 64'd65535) ? {SINE_W{1'b1}} : v[SINE_W-1:0];
    endfunction

endpackage

>>> rtl/core/led_effect_sequencer.sv
// Request flow: an apply runs APPLY then DONE, a tick while stopped goes straight to DONE,
// and a tick runs CHECK then EVAL, with a serial modulo in MOD when the time wraps (one
// bit per cycle over TIME_W bits). Breath adds an 8-bit index divide, then the scaler;
// the divide is skipped at the peak. An output stall holds DONE. One request in flight;
// the next is taken the cycle after the result is loaded.
// Async active-low reset clears the control state, settings and outputs; the sine sample is not reset.
module led_effect_sequencer
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [les_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [les_pkg::CFG_DATA_W-1:0]    cfg_data,
    // request channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              func,
    input  logic [les_pkg::ELAPSED_W-1:0]     elapsed_ms,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [les_pkg::COL_W-1:0]         out_red,
    output logic [les_pkg::COL_W-1:0]         out_green,
    output logic [les_pkg::COL_W-1:0]         out_blue,
    output logic                              running
);
    import les_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers (shadow copy, taken only on apply)
    // ------------------------------------------------------------------
    les_rgb_t               cfg_col_reg;
    logic [EFF_W-1:0]       cfg_eff_reg;
    logic [CFG_DATA_W-1:0]  cfg_p1_reg;
    logic [CFG_DATA_W-1:0]  cfg_p2_reg;
    logic                   cfg_rep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_col_reg <= '0;
            cfg_eff_reg <= EFF_OFF;
            cfg_p1_reg  <= '0;
            cfg_p2_reg  <= '0;
            cfg_rep_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RED:    cfg_col_reg[0] <= cfg_data[COL_W-1:0];
                REG_GREEN:  cfg_col_reg[1] <= cfg_data[COL_W-1:0];
                REG_BLUE:   cfg_col_reg[2] <= cfg_data[COL_W-1:0];
                REG_EFFECT: cfg_eff_reg    <= cfg_data[EFF_W-1:0];
                REG_P1:     cfg_p1_reg     <= cfg_data;
                REG_P2:     cfg_p2_reg     <= cfg_data;
                REG_REPEAT: cfg_rep_reg    <= cfg_data[0];
                default:    ;   // unmapped index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Effect state
    // ------------------------------------------------------------------
    les_state_t             state_reg, state_next;
    les_rgb_t               lat_col_reg, lat_col_next;
    logic [EFF_W-1:0]       lat_eff_reg, lat_eff_next;
    logic [PERIOD_BITS-1:0] lat_p1_reg, lat_p1_next;
    logic [PERIOD_BITS-1:0] lat_p2_reg, lat_p2_next;
    logic                   lat_rep_reg, lat_rep_next;
    logic [PER_W-1:0]       period_reg, period_next;
    logic [TIME_W-1:0]      time_reg, time_next;
    logic                   active_reg, active_next;
    les_rgb_t               shown_reg, shown_next;
    logic [SINE_W-1:0]      s_reg, s_next;
    logic                   out_valid_reg, out_valid_next;
    les_rgb_t               out_rgb_reg, out_rgb_next;
    logic                   out_run_reg, out_run_next;

    // Strobes from the output decoder and the serial units
    logic                   accept;
    logic                   out_load;
    logic                   scale_start;
    les_div_cmd_t           div_cmd;
    les_div_stat_t          div_stat;
    logic                   scale_done;
    les_rgb_t               scale_level;

    // Quarter-wave sine ROM, built at elaboration
    logic [SINE_W-1:0]      sine_rom [SINE_DEPTH];

    for (genvar g = 0; g < SINE_DEPTH; g++)
    begin : g_sine
        assign sine_rom[g] = les_sine_entry(g);
    end

    // ------------------------------------------------------------------
    // Shared decode of the current time against the latched settings
    // ------------------------------------------------------------------
    logic [PER_W-1:0]       p1_ext;
    logic [PER_W-1:0]       p2_ext;
    logic [PER_W-1:0]       p2_x15;
    logic [PER_W-1:0]       period_calc;
    logic                   time_over;
    logic                   time_below;
    logic                   stop_now;
    logic                   t_lt_p1;
    logic                   scroll_on;
    logic [TIME_W-1:0]      dt_raw;
    logic [PERIOD_BITS-1:0] dt_clip;
    logic [PERIOD_BITS-1:0] fall_x;
    logic                   fall_full;
    logic                   breath_div;

    assign p1_ext      = PER_W'(lat_p1_reg);
    assign p2_ext      = PER_W'(lat_p2_reg);
    assign p2_x15      = (p2_ext << 4) - p2_ext;
    // scroll: lead-in + off phase + floor(7.5 * p2); others: p1 + p2
    assign period_calc = (lat_eff_reg == EFF_SCROLL)
                       ? SCROLL_LEAD_MS + p1_ext + (p2_x15 >> 1)
                       : p1_ext + p2_ext;

    assign time_over   = time_reg > TIME_W'(period_reg);
    assign time_below  = time_reg < TIME_W'(period_reg);
    assign stop_now    = !lat_rep_reg && time_over;

    assign t_lt_p1     = time_reg < TIME_W'(p1_ext);
    assign scroll_on   = (time_reg < TIME_W'(SCROLL_LEAD_MS))
                      || (time_reg >= TIME_W'(SCROLL_LEAD_MS + p1_ext));

    // falling half: d = time - p1 clamped to p2, index from (p2 - d) / p2
    assign dt_raw      = time_reg - TIME_W'(p1_ext);
    assign dt_clip     = (dt_raw > TIME_W'(p2_ext)) ? lat_p2_reg : dt_raw[PERIOD_BITS-1:0];
    assign fall_x      = lat_p2_reg - dt_clip;
    assign fall_full   = (dt_clip == '0);
    assign breath_div  = t_lt_p1 || ((lat_p2_reg != '0) && !fall_full);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (func)
                        state_next = ST_APPLY;
                    else if (active_reg)
                        state_next = ST_CHECK;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_APPLY:
                state_next = ST_DONE;
            ST_CHECK:
            begin
                if (stop_now)
                    state_next = ST_DONE;
                else if (period_reg == '0 || time_below)
                    state_next = ST_EVAL;
                else
                    state_next = ST_MOD;
            end
            ST_MOD:
            begin
                if (div_stat.done)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (lat_eff_reg == EFF_BREATH && breath_div)
                    state_next = ST_INDEX;
                else if (lat_eff_reg == EFF_BREATH && lat_p2_reg != '0)
                    state_next = ST_SQUARE;
                else
                    state_next = ST_DONE;
            end
            ST_INDEX:
            begin
                if (div_stat.done)
                    state_next = ST_SQUARE;
            end
            ST_SQUARE:
                state_next = ST_SCALE;
            ST_SCALE:
            begin
                if (scale_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs of the sequencer: handshake and unit starts
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready    = 1'b0;
        out_load    = 1'b0;
        scale_start = 1'b0;
        div_cmd     = '0;
        unique case (state_reg)
            ST_IDLE:
                in_ready = 1'b1;
            ST_CHECK:
            begin
                // wrap only when the time reached the period
                if (!stop_now && period_reg != '0 && !time_below)
                begin
                    div_cmd.start    = 1'b1;
                    div_cmd.steps    = STEP_W'(TIME_W);
                    div_cmd.rem_init = '0;
                    div_cmd.dividend = time_reg;
                    div_cmd.divisor  = period_reg;
                end
            end
            ST_EVAL:
            begin
                if (lat_eff_reg == EFF_BREATH && breath_div)
                begin
                    div_cmd.start    = 1'b1;
                    div_cmd.steps    = STEP_W'(SINE_IDX_W);
                    div_cmd.dividend = '0;
                    if (t_lt_p1)
                    begin
                        div_cmd.rem_init = time_reg[PER_W-1:0];
                        div_cmd.divisor  = p1_ext;
                    end
                    else
                    begin
                        div_cmd.rem_init = PER_W'(fall_x);
                        div_cmd.divisor  = p2_ext;
                    end
                end
            end
            ST_SQUARE:
                scale_start = 1'b1;
            ST_DONE:
                out_load = !out_valid_reg || out_ready;
            default:
                ;
        endcase
    end

    assign accept = in_valid && in_ready;

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb
    begin
        lat_col_next   = lat_col_reg;
        lat_eff_next   = lat_eff_reg;
        lat_p1_next    = lat_p1_reg;
        lat_p2_next    = lat_p2_reg;
        lat_rep_next   = lat_rep_reg;
        period_next    = period_reg;
        time_next      = time_reg;
        active_next    = active_reg;
        shown_next     = shown_reg;
        s_next         = s_reg;
        out_rgb_next   = out_rgb_reg;
        out_run_next   = out_run_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && func)
                begin
                    lat_col_next = cfg_col_reg;
                    lat_eff_next = cfg_eff_reg;
                    lat_p1_next  = PERIOD_BITS'(cfg_p1_reg);
                    lat_p2_next  = PERIOD_BITS'(cfg_p2_reg);
                    lat_rep_next = cfg_rep_reg;
                    // off and on act at once; timed effects keep the shown colour
                    if (cfg_eff_reg == EFF_OFF)
                        shown_next = '0;
                    if (cfg_eff_reg == EFF_ON)
                        shown_next = cfg_col_reg;
                    active_next = (cfg_eff_reg != EFF_OFF) && (cfg_eff_reg != EFF_ON);
                    if (active_next)
                        time_next = '0;
                end
                else if (accept && active_reg)
                begin
                    time_next = time_reg + TIME_W'(elapsed_ms);
                end
            end
            ST_APPLY:
                period_next = period_calc;
            ST_CHECK:
            begin
                if (stop_now)
                    active_next = 1'b0;     // one-shot ran out, colour holds
                else if (period_reg == '0)
                    time_next = '0;
            end
            ST_MOD:
            begin
                if (div_stat.done)
                    time_next = TIME_W'(div_stat.rem);
            end
            ST_EVAL:
            begin
                case (lat_eff_reg)
                    EFF_FLASH:
                        shown_next = t_lt_p1 ? lat_col_reg : '0;
                    EFF_SCROLL:
                        shown_next = scroll_on ? lat_col_reg : '0;
                    EFF_BREATH:
                    begin
                        if (!t_lt_p1 && lat_p2_reg == '0)
                            shown_next = '0;
                        else if (!t_lt_p1 && fall_full)
                            s_next = {SINE_W{1'b1}};   // top of the wave
                    end
                    default:
                        ;   // unused codes run the timer only
                endcase
            end
            ST_INDEX:
            begin
                if (div_stat.done)
                    s_next = sine_rom[div_stat.quo];
            end
            ST_SCALE:
            begin
                if (scale_done)
                    shown_next = scale_level;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_rgb_next   = shown_reg;
                    out_run_next   = active_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lat_col_reg   <= '0;
            lat_eff_reg   <= EFF_OFF;
            lat_p1_reg    <= '0;
            lat_p2_reg    <= '0;
            lat_rep_reg   <= 1'b0;
            period_reg    <= '0;
            time_reg      <= '0;
            active_reg    <= 1'b0;
            shown_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_rgb_reg   <= '0;
            out_run_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lat_col_reg   <= lat_col_next;
            lat_eff_reg   <= lat_eff_next;
            lat_p1_reg    <= lat_p1_next;
            lat_p2_reg    <= lat_p2_next;
            lat_rep_reg   <= lat_rep_next;
            period_reg    <= period_next;
            time_reg      <= time_next;
            active_reg    <= active_next;
            shown_reg     <= shown_next;
            out_valid_reg <= out_valid_next;
            out_rgb_reg   <= out_rgb_next;
            out_run_reg   <= out_run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
    end

    // ------------------------------------------------------------------
    // Serial units
    // ------------------------------------------------------------------
    // Shared divider: time modulo period, and breath table index
    les_sdiv u_sdiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .stat  (div_stat)
    );

    les_scale u_scale
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scale_start),
        .s     (s_reg),
        .col   (lat_col_reg),
        .done  (scale_done),
        .level (scale_level)
    );

    assign out_valid = out_valid_reg;
    assign out_red   = out_rgb_reg[0];
    assign out_green = out_rgb_reg[1];
    assign out_blue  = out_rgb_reg[2];
    assign running   = out_run_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_cmd.start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_done_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && (!out_valid_reg || out_ready))
        |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result not loaded on completion");

    a_active_timed_only: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (lat_eff_reg != EFF_OFF && lat_eff_reg != EFF_ON))
        else $error("timer running for a static effect");

    a_time_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && active_reg && period_reg != '0)
        |-> (time_reg < TIME_W'(period_reg)))
        else $error("effect time not below period while idle");

endmodule

>>> rtl/core/les_sdiv.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Remainder starts at rem_init (must be below divisor), dividend bits shift in MSB first.
module les_sdiv
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  les_pkg::les_div_cmd_t cmd,
    output les_pkg::les_div_stat_t stat
);
    import les_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     cnt_reg, cnt_next;
    logic [PER_W-1:0]      rem_reg, rem_next;
    logic [TIME_W-1:0]     dvd_reg, dvd_next;
    logic [PER_W-1:0]      dvs_reg, dvs_next;
    logic [SINE_IDX_W-1:0] quo_reg, quo_next;

    logic [PER_W:0]        trial;
    logic [PER_W:0]        diff;
    logic                  fits;

    assign trial = {rem_reg, dvd_reg[TIME_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = cmd.steps;
            rem_next  = cmd.rem_init;
            dvd_next  = cmd.dividend;
            dvs_next  = cmd.divisor;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[PER_W-1:0] : trial[PER_W-1:0];
            dvd_next = {dvd_reg[TIME_W-2:0], 1'b0};
            quo_next = {quo_reg[SINE_IDX_W-2:0], fits};
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.quo  = quo_reg;
    assign stat.rem  = rem_reg;

endmodule

>>> rtl/core/les_scale.sv
// Breath brightness: level = round(c * s^2 / 2^32) per lane.
// s^2 is registered at start, then c is consumed one bit per cycle, MSB first.
module les_scale
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [les_pkg::SINE_W-1:0] s,
    input  les_pkg::les_rgb_t        col,
    output logic                     done,
    output les_pkg::les_rgb_t        level
);
    import les_pkg::*;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [SCALE_CNT_W-1:0] cnt_reg, cnt_next;
    logic [2*SINE_W-1:0]    ss_reg, ss_next;
    les_rgb_t               col_reg, col_next;
    logic [ACC_W-1:0]       acc_reg [3];
    logic [ACC_W-1:0]       acc_next [3];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        ss_next   = ss_reg;
        col_next  = col_reg;
        for (int k = 0; k < 3; k++)
        begin
            acc_next[k] = acc_reg[k];
        end
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = SCALE_CNT_W'(COL_W);
            ss_next   = (2*SINE_W)'(s) * (2*SINE_W)'(s);
            col_next  = col;
            for (int k = 0; k < 3; k++)
            begin
                acc_next[k] = '0;
            end
        end
        else if (busy_reg)
        begin
            for (int k = 0; k < 3; k++)
            begin
                acc_next[k] = {acc_reg[k][ACC_W-2:0], 1'b0}
                            + (col_reg[k][COL_W-1] ? ACC_W'(ss_reg) : '0);
                col_next[k] = {col_reg[k][COL_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - SCALE_CNT_W'(1);
            if (cnt_reg == SCALE_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ss_reg  <= ss_next;
        col_reg <= col_next;
        for (int k = 0; k < 3; k++)
        begin
            acc_reg[k] <= acc_next[k];
        end
    end

    // Rounding: adding 2^31 and taking the top byte is top byte plus bit 31.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            level[k] = acc_reg[k][ACC_W-1 -: COL_W] + COL_W'(acc_reg[k][ACC_W-COL_W-1]);
        end
    end

    assign done = done_reg;

endmodule
